### hdl/png_chunk_crc_validator_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef PNG_CHUNK_CRC_VALIDATOR_CORE_MACROS_SVH
`define PNG_CHUNK_CRC_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pcv_pkg.sv
package pcv_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL  = 32'hFFFF_FFFF;
  localparam logic [31:0] HDR_LEN  = 32'd13;
  localparam logic [31:0] HDR_BODY = 32'd17;  // type plus 13 data bytes
  localparam logic [31:0] FIELD4   = 32'd4;
  localparam logic [31:0] SIG_LEN  = 32'd8;

  // event codes on event_res
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_HDR_OK   = 4'd1;
  localparam logic [3:0] EV_BAD_SIG  = 4'd2;
  localparam logic [3:0] EV_BAD_HLEN = 4'd3;
  localparam logic [3:0] EV_BAD_HCRC = 4'd4;
  localparam logic [3:0] EV_CHUNK_OK = 4'd5;
  localparam logic [3:0] EV_CHUNK_BAD = 4'd6;
  localparam logic [3:0] EV_END_OK   = 4'd7;
  localparam logic [3:0] EV_END_BAD  = 4'd8;

  typedef enum logic [8:0] {
    PH_SIG   = 9'b0_0000_0001,
    PH_HLEN  = 9'b0_0000_0010,
    PH_HBODY = 9'b0_0000_0100,
    PH_HCRC  = 9'b0_0000_1000,
    PH_LEN   = 9'b0_0001_0000,
    PH_TYPE  = 9'b0_0010_0000,
    PH_DATA  = 9'b0_0100_0000,
    PH_CRC   = 9'b0_1000_0000,
    PH_DONE  = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] event_res;
    logic       stream_done;
  } res_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd137;
      3'd1: v = 8'd80;
      3'd2: v = 8'd78;
      3'd3: v = 8'd71;
      3'd4: v = 8'd13;
      3'd5: v = 8'd10;
      3'd6: v = 8'd26;
      default: v = 8'd10;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] end_tag(logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'h49;
      2'd1: v = 8'h45;
      2'd2: v = 8'h4e;
      default: v = 8'h44;
    endcase
    return v;
  endfunction

endpackage

### hdl/pcv_parser.sv
// Chunk parser: field counters, running CRC and the mode register.
module pcv_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_start_i,
  output pcv_pkg::res_t    res_o
);

  pcv_pkg::phase_e phase_q, phase_d, phase_c;
  logic [31:0] cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [31:0] len_q, len_d, len_c, len_sh;
  logic [31:0] crc_q, crc_d, crc_c, crc_fin;
  logic [31:0] rcv_q, rcv_d, rcv_c, rcv_sh;
  logic        end_q, end_d, end_c;
  logic        fin_q, fin_d, fin_c;
  logic        inv_q;
  logic        rewrite;
  logic [1:0]  byte_sel;
  logic [7:0]  ob;
  logic [3:0]  ev;

  always_comb begin
    // a frame start restarts the parse on this very byte
    if (frame_start_i) begin
      phase_c = pcv_pkg::PH_SIG;
      cnt_c   = '0;
      len_c   = '0;
      crc_c   = pcv_pkg::CRC_ALL;
      rcv_c   = '0;
      end_c   = 1'b0;
      fin_c   = 1'b0;
    end else begin
      phase_c = phase_q;
      cnt_c   = cnt_q;
      len_c   = len_q;
      crc_c   = crc_q;
      rcv_c   = rcv_q;
      end_c   = end_q;
      fin_c   = fin_q;
    end
  end

  assign cnt_inc  = cnt_c + 32'd1;
  assign len_sh   = {len_c[23:0], data_byte_i};
  assign rcv_sh   = {rcv_c[23:0], data_byte_i};
  assign crc_fin  = crc_c ^ pcv_pkg::CRC_ALL;
  assign rewrite  = inv_q & ~end_c;
  assign byte_sel = 2'd3 - cnt_c[1:0];

  always_comb begin
    phase_d = phase_c;
    cnt_d   = cnt_c;
    len_d   = len_c;
    crc_d   = crc_c;
    rcv_d   = rcv_c;
    end_d   = end_c;
    fin_d   = fin_c;
    ob      = data_byte_i;
    ev      = pcv_pkg::EV_NONE;
    if (!fin_c) begin
      unique case (phase_c)
        pcv_pkg::PH_SIG: begin
          if (data_byte_i != pcv_pkg::sig_byte(cnt_c[2:0])) begin
            ev      = pcv_pkg::EV_BAD_SIG;
            fin_d   = 1'b1;
            phase_d = pcv_pkg::PH_DONE;
          end else if (cnt_inc == pcv_pkg::SIG_LEN) begin
            cnt_d   = '0;
            len_d   = '0;
            phase_d = pcv_pkg::PH_HLEN;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        pcv_pkg::PH_HLEN: begin
          len_d = len_sh;
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::FIELD4) begin
            cnt_d = '0;
            if (len_sh != pcv_pkg::HDR_LEN) begin
              ev      = pcv_pkg::EV_BAD_HLEN;
              fin_d   = 1'b1;
              phase_d = pcv_pkg::PH_DONE;
            end else begin
              crc_d   = pcv_pkg::CRC_ALL;
              phase_d = pcv_pkg::PH_HBODY;
            end
          end
        end
        pcv_pkg::PH_HBODY: begin
          crc_d = pcv_pkg::crc_byte(crc_c, data_byte_i);
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::HDR_BODY) begin
            cnt_d   = '0;
            rcv_d   = '0;
            phase_d = pcv_pkg::PH_HCRC;
          end
        end
        pcv_pkg::PH_HCRC: begin
          rcv_d = rcv_sh;
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::FIELD4) begin
            cnt_d = '0;
            if (rcv_sh == crc_fin) begin
              ev      = pcv_pkg::EV_HDR_OK;
              len_d   = '0;
              phase_d = pcv_pkg::PH_LEN;
            end else begin
              ev      = pcv_pkg::EV_BAD_HCRC;
              fin_d   = 1'b1;
              phase_d = pcv_pkg::PH_DONE;
            end
          end
        end
        pcv_pkg::PH_LEN: begin
          len_d = len_sh;
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::FIELD4) begin
            cnt_d   = '0;
            crc_d   = pcv_pkg::CRC_ALL;
            end_d   = 1'b1;
            phase_d = pcv_pkg::PH_TYPE;
          end
        end
        pcv_pkg::PH_TYPE: begin
          if (data_byte_i != pcv_pkg::end_tag(cnt_c[1:0])) begin
            end_d = 1'b0;
          end
          crc_d = pcv_pkg::crc_byte(crc_c, data_byte_i);
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::FIELD4) begin
            cnt_d   = '0;
            rcv_d   = '0;
            phase_d = (len_c == '0) ? pcv_pkg::PH_CRC : pcv_pkg::PH_DATA;
          end
        end
        pcv_pkg::PH_DATA: begin
          if (rewrite) begin
            ob = ~data_byte_i;
          end
          crc_d = pcv_pkg::crc_byte(crc_c, ob);
          cnt_d = cnt_inc;
          if (cnt_inc == len_c) begin
            cnt_d   = '0;
            phase_d = pcv_pkg::PH_CRC;
          end
        end
        pcv_pkg::PH_CRC: begin
          if (rewrite) begin
            ob = crc_fin[{byte_sel, 3'b000} +: 8];
          end
          rcv_d = rcv_sh;
          cnt_d = cnt_inc;
          if (cnt_inc == pcv_pkg::FIELD4) begin
            cnt_d = '0;
            if (end_c) begin
              ev      = (rcv_sh == crc_fin) ? pcv_pkg::EV_END_OK : pcv_pkg::EV_END_BAD;
              fin_d   = 1'b1;
              phase_d = pcv_pkg::PH_DONE;
            end else begin
              ev      = (rewrite || rcv_sh == crc_fin) ? pcv_pkg::EV_CHUNK_OK
                                                       : pcv_pkg::EV_CHUNK_BAD;
              len_d   = '0;
              phase_d = pcv_pkg::PH_LEN;
            end
          end
        end
        default: begin
          fin_d   = 1'b1;
          phase_d = pcv_pkg::PH_DONE;
        end
      endcase
    end
  end

  assign res_o.out_byte    = ob;
  assign res_o.event_res   = ev;
  assign res_o.stream_done = fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcv_pkg::PH_SIG;
      cnt_q   <= '0;
      len_q   <= '0;
      crc_q   <= pcv_pkg::CRC_ALL;
      rcv_q   <= '0;
      end_q   <= 1'b0;
      fin_q   <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        crc_q   <= crc_d;
        rcv_q   <= rcv_d;
        end_q   <= end_d;
        fin_q   <= fin_d;
      end
    end
  end

endmodule

### hdl/pcv_out_buf.sv
// Output register with one skid entry; stall toward the source is registered.
module pcv_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcv_pkg::res_t in_res_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pcv_pkg::res_t out_res_o
);

  logic          out_valid_q, skid_valid_q;
  pcv_pkg::res_t out_q, skid_q;
  logic          accept, take;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign take       = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : in_res_i;
    end
    if (accept && out_valid_q && !take) begin
      skid_q <= in_res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### hdl/png_chunk_crc_validator_core.sv
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+------------------------------------------
// in       | sink      | in_valid_i/in_stall_o   | data_byte_i, frame_start_i
// out      | source    | out_valid_o/out_stall_i | out_byte_o, event_res_o, stream_done_o
// cfg      | sink      | cfg_we_i            | cfg_wdata_i (invert mode)
//
// One word in per cycle while in_stall_o is low, one word out per input word;
// an accepted word enters the output register, or the skid entry if stalled.
// Per-byte work is a single table-free CRC byte update plus the field counter
// compare, all between the parser state and the output register.
// Reset (rst_ni low, async) clears the parse state and the invert mode.
// in_stall_o is the registered skid-full flag: a word taken while the output
// is stalled goes to the skid entry, and input then pauses until it drains.
module png_chunk_crc_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] event_res_o,
  output logic       stream_done_o
);

  pcv_pkg::res_t res, out_res;
  logic          step;

  // a word is taken whenever the skid entry is free
  assign step = in_valid_i & ~in_stall_o;

  pcv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .step_i        (step),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .res_o         (res)
  );

  pcv_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_res_i    (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o    = out_res.out_byte;
  assign event_res_o   = out_res.event_res;
  assign stream_done_o = out_res.stream_done;

endmodule

### hdl/pcv_checker.sv
`include "png_chunk_crc_validator_core_macros.svh"

module pcv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [3:0] event_res_o,
  input logic       stream_done_o
);

  // stalled output word holds
  `PCV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(event_res_o) && $stable(stream_done_o), "output word changed under stall")

  `PCV_ASSERT_IMPL(a_ev_range, out_valid_o, event_res_o <= pcv_pkg::EV_END_BAD, "event code out of range")

  // fatal and end events finish the stream
  `PCV_ASSERT_IMPL(a_fatal_done, out_valid_o && (event_res_o == pcv_pkg::EV_BAD_SIG || event_res_o == pcv_pkg::EV_BAD_HLEN || event_res_o == pcv_pkg::EV_BAD_HCRC || event_res_o == pcv_pkg::EV_END_OK || event_res_o == pcv_pkg::EV_END_BAD), stream_done_o, "finishing event without stream_done")

  // header and chunk results only come while the stream is open
  `PCV_ASSERT_IMPL(a_open_ev, out_valid_o && (event_res_o == pcv_pkg::EV_HDR_OK || event_res_o == pcv_pkg::EV_CHUNK_OK || event_res_o == pcv_pkg::EV_CHUNK_BAD), !stream_done_o, "chunk event with stream_done set")

endmodule

bind png_chunk_crc_validator_core pcv_checker u_pcv_checker (.*);

### verif/tb_png_chunk_crc_validator_core.sv
`timescale 1ns / 1ps

module tb_png_chunk_crc_validator_core;

  // run guard, far above the slowest legal run (longest random streams, widest gaps on both sides)
  localparam int unsigned CYCLE_LIMIT = 200000;
  // PNG magic and the end, header and data chunk tags, most significant byte first
  localparam logic [63:0] PNG_SIG  = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] IEND_TAG = 32'h4945_4E44;
  localparam logic [31:0] IHDR_TAG = 32'h4948_4452;
  localparam logic [31:0] IDAT_TAG = 32'h4944_4154;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } feed_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i   = 8'd0;
  logic       frame_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic [3:0] event_res_o;
  logic       stream_done_o;

  png_chunk_crc_validator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .event_res_o   (event_res_o),
    .stream_done_o (stream_done_o)
  );

  // words waiting to be sent, and predicted output words in arrival order
  feed_t          byte_feed[$];
  pcv_pkg::res_t  expected_words[$];
  logic [7:0]     file_bytes[$];

  int unsigned err_cnt   = 0;
  int unsigned out_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_wait   = 0;
  int unsigned rx_wait   = 0;
  int unsigned burst_left[2];

  // parser copy: one entry per state field of the block, plus the invert register
  pcv_pkg::phase_e ph;
  logic [31:0]     fld_cnt;
  logic [31:0]     chunk_len;
  logic [31:0]     crc_acc;
  logic [31:0]     crc_seen;
  logic            end_chunk;
  logic            stream_over;
  logic            invert_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Reflected CRC-32, fed LSB first one bit at a time.
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c;
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ ((x[0] ^ b[i]) ? pcv_pkg::CRC_POLY : 32'd0);
    end
    return x;
  endfunction

  function automatic void clear_parse();
    ph          = pcv_pkg::PH_SIG;
    fld_cnt     = '0;
    chunk_len   = '0;
    crc_acc     = pcv_pkg::CRC_ALL;
    crc_seen    = '0;
    end_chunk   = 1'b0;
    stream_over = 1'b0;
  endfunction

  // Advance the parser copy by one byte and return the word it must produce.
  function automatic pcv_pkg::res_t parse_byte(logic [7:0] b, logic fs);
    pcv_pkg::res_t r;
    logic [31:0]   crc_fin;
    logic          rewrite;
    r.out_byte  = b;
    r.event_res = pcv_pkg::EV_NONE;
    if (fs) clear_parse();
    if (!stream_over) begin
      case (ph)
        pcv_pkg::PH_SIG: begin
          if (b != PNG_SIG[63 - 8 * fld_cnt[2:0] -: 8]) begin
            r.event_res = pcv_pkg::EV_BAD_SIG;
            stream_over = 1'b1;
            ph = pcv_pkg::PH_DONE;
          end else begin
            fld_cnt = fld_cnt + 1;
            if (fld_cnt == pcv_pkg::SIG_LEN) begin
              fld_cnt = '0;
              chunk_len = '0;
              ph = pcv_pkg::PH_HLEN;
            end
          end
        end
        pcv_pkg::PH_HLEN: begin
          chunk_len = {chunk_len[23:0], b};
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::FIELD4) begin
            fld_cnt = '0;
            if (chunk_len != pcv_pkg::HDR_LEN) begin
              r.event_res = pcv_pkg::EV_BAD_HLEN;
              stream_over = 1'b1;
              ph = pcv_pkg::PH_DONE;
            end else begin
              crc_acc = pcv_pkg::CRC_ALL;
              ph = pcv_pkg::PH_HBODY;
            end
          end
        end
        pcv_pkg::PH_HBODY: begin
          // header type and data: never inverted
          crc_acc = crc_step(crc_acc, b);
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::HDR_BODY) begin
            fld_cnt = '0;
            crc_seen = '0;
            ph = pcv_pkg::PH_HCRC;
          end
        end
        pcv_pkg::PH_HCRC: begin
          crc_seen = {crc_seen[23:0], b};
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::FIELD4) begin
            fld_cnt = '0;
            if (crc_seen == (crc_acc ^ pcv_pkg::CRC_ALL)) begin
              r.event_res = pcv_pkg::EV_HDR_OK;
              chunk_len = '0;
              ph = pcv_pkg::PH_LEN;
            end else begin
              r.event_res = pcv_pkg::EV_BAD_HCRC;
              stream_over = 1'b1;
              ph = pcv_pkg::PH_DONE;
            end
          end
        end
        pcv_pkg::PH_LEN: begin
          chunk_len = {chunk_len[23:0], b};
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::FIELD4) begin
            fld_cnt = '0;
            crc_acc = pcv_pkg::CRC_ALL;
            end_chunk = 1'b1;
            ph = pcv_pkg::PH_TYPE;
          end
        end
        pcv_pkg::PH_TYPE: begin
          if (b != IEND_TAG[31 - 8 * fld_cnt[1:0] -: 8]) end_chunk = 1'b0;
          crc_acc = crc_step(crc_acc, b);
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::FIELD4) begin
            fld_cnt = '0;
            crc_seen = '0;
            // zero length: CRC follows the type directly
            ph = (chunk_len == 0) ? pcv_pkg::PH_CRC : pcv_pkg::PH_DATA;
          end
        end
        pcv_pkg::PH_DATA: begin
          if (invert_on && !end_chunk) r.out_byte = ~b;
          // CRC runs over the byte as it leaves
          crc_acc = crc_step(crc_acc, r.out_byte);
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == chunk_len) begin
            fld_cnt = '0;
            ph = pcv_pkg::PH_CRC;
          end
        end
        pcv_pkg::PH_CRC: begin
          crc_fin = crc_acc ^ pcv_pkg::CRC_ALL;
          rewrite = invert_on && !end_chunk;
          if (rewrite) r.out_byte = crc_fin[31 - 8 * fld_cnt[1:0] -: 8];
          crc_seen = {crc_seen[23:0], b};
          fld_cnt = fld_cnt + 1;
          if (fld_cnt == pcv_pkg::FIELD4) begin
            fld_cnt = '0;
            if (end_chunk) begin
              r.event_res = (crc_seen == crc_fin) ? pcv_pkg::EV_END_OK
                                                  : pcv_pkg::EV_END_BAD;
              stream_over = 1'b1;
              ph = pcv_pkg::PH_DONE;
            end else begin
              r.event_res = (rewrite || crc_seen == crc_fin) ? pcv_pkg::EV_CHUNK_OK
                                                             : pcv_pkg::EV_CHUNK_BAD;
              chunk_len = '0;
              ph = pcv_pkg::PH_LEN;
            end
          end
        end
        default: begin
          stream_over = 1'b1;
          ph = pcv_pkg::PH_DONE;
        end
      endcase
    end
    r.stream_done = stream_over;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Wait before the next word (side 0 sender, 1 receiver): a uniform random wait,
  // with occasional runs of back-to-back words.
  function automatic int unsigned draw_wait(int side);
    if (burst_left[side] > 0) begin
      burst_left[side] = burst_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic feed_byte(logic [7:0] b, logic fs);
    feed_t w;
    w.data = b;
    w.fs   = fs;
    byte_feed.push_back(w);
  endtask

  // Append one chunk to file_bytes: length, type, random data, CRC (optionally damaged).
  task automatic add_chunk(logic [31:0] ctype, logic [31:0] len, bit bad_crc);
    logic [31:0] crc;
    logic [7:0]  b;
    crc = pcv_pkg::CRC_ALL;
    for (int k = 0; k < 4; k++) file_bytes.push_back(len[31 - 8 * k -: 8]);
    for (int k = 0; k < 4; k++) begin
      b = ctype[31 - 8 * k -: 8];
      file_bytes.push_back(b);
      crc = crc_step(crc, b);
    end
    for (int k = 0; k < len; k++) begin
      b = $urandom_range(0, 255);
      file_bytes.push_back(b);
      crc = crc_step(crc, b);
    end
    crc = crc ^ pcv_pkg::CRC_ALL;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) file_bytes.push_back(crc[31 - 8 * k -: 8]);
  endtask

  // One PNG stream: signature, header, a few chunks, end chunk, maybe trailing
  // junk; some streams get a damaged byte or are cut short.
  task automatic add_file();
    logic [31:0] ctype;
    logic [7:0]  junk;
    int unsigned n_chunks;
    int unsigned pos;
    int unsigned flaw;
    file_bytes.delete();
    for (int k = 0; k < 8; k++) file_bytes.push_back(PNG_SIG[63 - 8 * k -: 8]);
    add_chunk(IHDR_TAG, pcv_pkg::HDR_LEN, 1'b0);
    n_chunks = $urandom_range(0, 3);
    for (int n = 0; n < n_chunks; n++) begin
      case ($urandom_range(0, 3))
        0:       ctype = IDAT_TAG;
        1:       ctype = IEND_TAG ^ (32'd1 << $urandom_range(0, 31));  // one bit off the end tag
        default: ctype = $urandom;
      endcase
      add_chunk(ctype, ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5),
                $urandom_range(0, 3) == 0);
    end
    add_chunk(IEND_TAG, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0,
              $urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 3)) file_bytes.push_back($urandom_range(0, 255));
    flaw = $urandom_range(0, 7);
    if (flaw < 2) begin
      // half the time hit signature or header, else anywhere
      pos = $urandom_range(0, 1) ? $urandom_range(0, 32) : $urandom_range(0, file_bytes.size() - 1);
      file_bytes[pos] = file_bytes[pos] ^ $urandom_range(1, 255);
    end else if (flaw == 2) begin
      pos = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > pos) junk = file_bytes.pop_back();
    end
    for (int k = 0; k < file_bytes.size(); k++)
      feed_byte(file_bytes[k], k == 0 && $urandom_range(0, 7) != 0);
  endtask

  // Sender: one word in flight; on acceptance the word goes through the parser
  // copy and the next word is loaded after its drawn gap.
  always @(posedge clk_i) begin : drive
    logic  send_nxt;
    feed_t w;
    if (rst_ni) begin
      send_nxt = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(parse_byte(data_byte_i, frame_start_i));
        send_nxt = 1'b0;
        tx_wait = draw_wait(0);
      end
      if (!send_nxt) begin
        if (tx_wait > 0) begin
          tx_wait = tx_wait - 1;
        end else if (byte_feed.size() > 0) begin
          w = byte_feed.pop_front();
          data_byte_i   <= w.data;
          frame_start_i <= w.fs;
          send_nxt = 1'b1;
        end
      end
      in_valid_i <= send_nxt;
    end
  end

  // Receiver: check each accepted word against the oldest prediction, then
  // hold stall for the drawn number of cycles.
  always @(posedge clk_i) begin : watch
    pcv_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", out_cnt));
        end else begin
          want = expected_words.pop_front();
          if (out_byte_o !== want.out_byte)
            report_mismatch($sformatf("word %0d out_byte %h, want %h",
                                      out_cnt, out_byte_o, want.out_byte));
          if (event_res_o !== want.event_res)
            report_mismatch($sformatf("word %0d event_res %0d, want %0d",
                                      out_cnt, event_res_o, want.event_res));
          if (stream_done_o !== want.stream_done)
            report_mismatch($sformatf("word %0d stream_done %b, want %b",
                                      out_cnt, stream_done_o, want.stream_done));
        end
        out_cnt++;
        rx_wait = draw_wait(1);
      end
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned feed_goal;
    logic        mode;
    burst_left[0] = 0;
    burst_left[1] = 0;
    invert_on = 1'b0;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Four settings, alternating plain and invert mode. Each starts idle: the
    // sender has drained and every predicted word has come back.
    for (int setting = 0; setting < 4; setting++) begin
      mode = setting[0];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= mode;
      @(posedge clk_i);
      cfg_we_i  <= 1'b0;
      invert_on = mode;

      if (setting == 0) begin
        // all-ones byte fails the signature on the first byte
        feed_byte(8'hFF, 1'b1);
        // finished stream: zero byte passes through, done stays high
        feed_byte(8'h00, 1'b0);
        // full signature, then a length of all ones
        for (int k = 0; k < 8; k++) feed_byte(PNG_SIG[63 - 8 * k -: 8], k == 0);
        repeat (4) feed_byte(8'hFF, 1'b0);
        feed_byte(8'h5A, 1'b0);
        // signature wrong only in its last byte
        for (int k = 0; k < 7; k++) feed_byte(PNG_SIG[63 - 8 * k -: 8], k == 0);
        feed_byte(8'h0B, 1'b0);
      end

      // Random part: mostly well-formed streams, some short noise runs.
      feed_goal = byte_feed.size() + 65;
      while (byte_feed.size() < feed_goal) begin
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 6)) feed_byte($urandom_range(0, 255), $urandom_range(0, 1));
        else
          add_file();
      end

      while (byte_feed.size() != 0 || in_valid_i || expected_words.size() != 0)
        @(posedge clk_i);
    end

    // idle on after the last word to catch stray words
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/pcv_pkg.sv
hdl/pcv_parser.sv
hdl/pcv_out_buf.sv
hdl/png_chunk_crc_validator_core.sv
hdl/pcv_checker.sv
verif/tb_png_chunk_crc_validator_core.sv
